// ===== hdl/tiered_wildcard_table_match_defines.svh =====
// assertion macros shared by the rtl files
`ifndef TIERED_WILDCARD_TABLE_MATCH_DEFINES_SVH
`define TIERED_WILDCARD_TABLE_MATCH_DEFINES_SVH

`ifndef SYNTHESIS

`define TWTM_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define TWTM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define TWTM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TWTM_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define TWTM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define TWTM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hdl/twtm_pkg.sv =====
`default_nettype none

package twtm_pkg;

    localparam int IDX_W     = 6;
    localparam int DRV_W     = 8;
    localparam int MFCT_W    = 24;
    localparam int VER_W     = 8;
    localparam int TYPE_W    = 8;
    localparam int LEVEL_W   = 2;
    localparam int COUNT_W   = 7;
    localparam int ENTRY_W   = MFCT_W + VER_W + TYPE_W + DRV_W;
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 16;

    localparam logic [VER_W-1:0]  ANY_VERSION = 8'hFF;
    localparam logic [TYPE_W-1:0] ANY_TYPE    = 8'hFF;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam logic [LEVEL_W-1:0] LVL_NONE      = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_EXACT     = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_MFCT_TYPE = 2'd2;
    localparam logic [LEVEL_W-1:0] LVL_MFCT      = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic entry_write;
        logic probe_load;
        logic scan_step;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic scan_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/twtm_ram.sv =====
`default_nettype none

module twtm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hdl/twtm_ctrl.sv =====
`default_nettype none

`include "tiered_wildcard_table_match_defines.svh"

module twtm_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic                  command,
    input  wire twtm_pkg::dp_status_t  status,
    output twtm_pkg::ctrl_cmd_t        cmd
);

    twtm_pkg::state_t state_reg;
    twtm_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= twtm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            twtm_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (command == twtm_pkg::CMD_LOOKUP)
                    begin
                        cmd.probe_load = 1'b1;
                        state_next = status.count_zero ? twtm_pkg::ST_DONE
                                                       : twtm_pkg::ST_SCAN;
                    end
                    else
                    begin
                        cmd.entry_write = 1'b1;
                    end
                end
            end
            twtm_pkg::ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = twtm_pkg::ST_WAIT;
                end
            end
            twtm_pkg::ST_WAIT:
            begin
                state_next = twtm_pkg::ST_DONE;
            end
            twtm_pkg::ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next = twtm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = twtm_pkg::ST_IDLE;
            end
        endcase
    end

    // a word is only taken while no lookup is in progress
    `TWTM_ASSERT_IMPL(a_ready_idle, clk, rst_n, s_tready, state_reg == twtm_pkg::ST_IDLE, "ready outside idle")
    `TWTM_ASSERT_NEXT(a_empty_lookup, clk, rst_n, cmd.probe_load && status.count_zero, state_reg == twtm_pkg::ST_DONE, "empty table lookup did not finish")
    `TWTM_ASSERT_NEXT(a_done_exit, clk, rst_n, cmd.out_load, state_reg == twtm_pkg::ST_IDLE, "result issue did not return to idle")

endmodule

`default_nettype wire

// ===== hdl/twtm_dp.sv =====
`default_nettype none

`include "tiered_wildcard_table_match_defines.svh"

module twtm_dp #(
    parameter int MAX_ENTRIES = 64
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire twtm_pkg::ctrl_cmd_t                  cmd,
    output twtm_pkg::dp_status_t                      status,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [twtm_pkg::COUNT_W-1:0]         cfg_wr_data,
    input  wire logic [twtm_pkg::IDX_W-1:0]           entry_index,
    input  wire logic [twtm_pkg::DRV_W-1:0]           entry_driver,
    input  wire logic [twtm_pkg::MFCT_W-1:0]          mfct_code,
    input  wire logic [twtm_pkg::VER_W-1:0]           version,
    input  wire logic [twtm_pkg::TYPE_W-1:0]          device_type,
    input  wire logic                                 m_tready,
    output logic                                      m_tvalid,
    output logic                                      found,
    output logic      [twtm_pkg::DRV_W-1:0]           driver_number,
    output logic      [twtm_pkg::LEVEL_W-1:0]         match_level
);

    localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W  = ($clog2(MAX_ENTRIES + 1) > twtm_pkg::COUNT_W)
                          ? $clog2(MAX_ENTRIES + 1) : twtm_pkg::COUNT_W;

    logic [twtm_pkg::COUNT_W-1:0] entry_count_reg;
    logic [ADDR_W-1:0]            addr_reg;
    logic [ADDR_W-1:0]            addr_next;
    logic                         cmp_en_reg;
    logic [CNT_W-1:0]             count_ext;
    logic [CNT_W-1:0]             limit;
    logic                         idx_ok;

    logic [twtm_pkg::MFCT_W-1:0]  probe_mfct_reg;
    logic [twtm_pkg::VER_W-1:0]   probe_ver_reg;
    logic [twtm_pkg::TYPE_W-1:0]  probe_type_reg;

    logic [twtm_pkg::ENTRY_W-1:0] wr_entry;
    logic [twtm_pkg::ENTRY_W-1:0] rd_entry;
    logic [twtm_pkg::MFCT_W-1:0]  rd_mfct;
    logic [twtm_pkg::VER_W-1:0]   rd_ver;
    logic [twtm_pkg::TYPE_W-1:0]  rd_type;
    logic [twtm_pkg::DRV_W-1:0]   rd_drv;

    logic                         mfct_eq;
    logic                         ver_ok;
    logic                         type_ok;
    logic                         hit_exact;
    logic                         hit_type;

    logic                         have_exact_reg;
    logic                         have_type_reg;
    logic                         have_mfct_reg;
    logic [twtm_pkg::DRV_W-1:0]   drv_exact_reg;
    logic [twtm_pkg::DRV_W-1:0]   drv_type_reg;
    logic [twtm_pkg::DRV_W-1:0]   drv_mfct_reg;

    logic                         res_found;
    logic [twtm_pkg::DRV_W-1:0]   res_drv;
    logic [twtm_pkg::LEVEL_W-1:0] res_level;

    logic                         m_tvalid_reg;
    logic                         m_tvalid_next;
    logic                         found_reg;
    logic [twtm_pkg::DRV_W-1:0]   driver_reg;
    logic [twtm_pkg::LEVEL_W-1:0] level_reg;

    // saturate the count to the table depth
    assign count_ext = CNT_W'(entry_count_reg);
    assign limit     = (count_ext > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : count_ext;
    assign idx_ok    = (32'(entry_index) < 32'(MAX_ENTRIES));
    assign addr_next = addr_reg + ADDR_W'(1);

    assign status.count_zero = (limit == '0);
    assign status.scan_last  = ((CNT_W'(addr_reg) + CNT_W'(1)) == limit);
    assign status.out_free   = !m_tvalid_reg || m_tready;

    assign wr_entry = {entry_driver, device_type, version, mfct_code};

    twtm_ram #(
        .WIDTH (twtm_pkg::ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (cmd.entry_write && idx_ok),
        .wr_addr (ADDR_W'(entry_index)),
        .wr_data (wr_entry),
        .rd_en   (cmd.scan_step),
        .rd_addr (addr_reg),
        .rd_data (rd_entry)
    );

    assign rd_mfct = rd_entry[twtm_pkg::MFCT_W-1:0];
    assign rd_ver  = rd_entry[twtm_pkg::MFCT_W +: twtm_pkg::VER_W];
    assign rd_type = rd_entry[twtm_pkg::MFCT_W + twtm_pkg::VER_W +: twtm_pkg::TYPE_W];
    assign rd_drv  = rd_entry[twtm_pkg::ENTRY_W-1 -: twtm_pkg::DRV_W];

    // all three tiers judged on each entry as it streams past
    assign mfct_eq   = (rd_mfct == probe_mfct_reg);
    assign ver_ok    = (rd_ver == twtm_pkg::ANY_VERSION) || (rd_ver == probe_ver_reg);
    assign type_ok   = (rd_type == twtm_pkg::ANY_TYPE) || (rd_type == probe_type_reg);
    assign hit_type  = mfct_eq && type_ok;
    assign hit_exact = hit_type && ver_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
            addr_reg        <= '0;
            cmp_en_reg      <= 1'b0;
            have_exact_reg  <= 1'b0;
            have_type_reg   <= 1'b0;
            have_mfct_reg   <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                entry_count_reg <= cfg_wr_data;
            end
            cmp_en_reg   <= cmd.scan_step;
            m_tvalid_reg <= m_tvalid_next;
            if (cmd.probe_load)
            begin
                addr_reg       <= '0;
                have_exact_reg <= 1'b0;
                have_type_reg  <= 1'b0;
                have_mfct_reg  <= 1'b0;
            end
            else
            begin
                if (cmd.scan_step)
                begin
                    addr_reg <= addr_next;
                end
                if (cmp_en_reg)
                begin
                    if (hit_exact)
                    begin
                        have_exact_reg <= 1'b1;
                    end
                    if (hit_type)
                    begin
                        have_type_reg <= 1'b1;
                    end
                    if (mfct_eq)
                    begin
                        have_mfct_reg <= 1'b1;
                    end
                end
            end
        end
    end

    // probe capture, first hit per tier in table order, and the result register load
    always_ff @(posedge clk)
    begin
        if (cmd.probe_load)
        begin
            probe_mfct_reg <= mfct_code;
            probe_ver_reg  <= version;
            probe_type_reg <= device_type;
        end
        if (cmp_en_reg && hit_exact && !have_exact_reg)
        begin
            drv_exact_reg <= rd_drv;
        end
        if (cmp_en_reg && hit_type && !have_type_reg)
        begin
            drv_type_reg <= rd_drv;
        end
        if (cmp_en_reg && mfct_eq && !have_mfct_reg)
        begin
            drv_mfct_reg <= rd_drv;
        end
        if (cmd.out_load)
        begin
            found_reg  <= res_found;
            driver_reg <= res_drv;
            level_reg  <= res_level;
        end
    end

    always_comb
    begin
        res_found = 1'b1;
        res_drv   = '0;
        res_level = twtm_pkg::LVL_NONE;
        if (have_exact_reg)
        begin
            res_drv   = drv_exact_reg;
            res_level = twtm_pkg::LVL_EXACT;
        end
        else if (have_type_reg)
        begin
            res_drv   = drv_type_reg;
            res_level = twtm_pkg::LVL_MFCT_TYPE;
        end
        else if (have_mfct_reg)
        begin
            res_drv   = drv_mfct_reg;
            res_level = twtm_pkg::LVL_MFCT;
        end
        else
        begin
            res_found = 1'b0;
        end
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    assign m_tvalid      = m_tvalid_reg;
    assign found         = found_reg;
    assign driver_number = driver_reg;
    assign match_level   = level_reg;

    `TWTM_ASSERT_IMPL(a_scan_bound, clk, rst_n, cmd.scan_step, CNT_W'(addr_reg) < limit, "read beyond entry count")
    `TWTM_ASSERT_IMPL(a_no_overwrite, clk, rst_n, cmd.out_load && m_tvalid_reg, m_tready, "pending result overwritten")
    `TWTM_ASSERT_IMPL(a_found_level, clk, rst_n, m_tvalid_reg, found_reg == (level_reg != twtm_pkg::LVL_NONE), "found flag disagrees with level")
    `TWTM_ASSERT_IMPL(a_tier_order, clk, rst_n, have_exact_reg, have_type_reg && have_mfct_reg, "tier hit flags inconsistent")

endmodule

`default_nettype wire

// ===== hdl/tiered_wildcard_table_match.sv =====
// channel   dir  signals                         word
// s_        in   s_tvalid s_tready s_tdata s_tuser  one load or lookup command
// cfg_      in   cfg_wr_en cfg_wr_data              entry count register
// m_        out  m_tvalid m_tready m_tdata          lookup result
//
// a load gives no result and leaves the block ready for the next word
// a lookup scans entries 0 to n - 1, n being the entry count saturated to
// MAX_ENTRIES (no scan when n is 0), then loads the output register once it
// is free; the next word is taken after that load; one table entry is read per
// cycle from the single read port of the table ram, all three tiers compared at once
// reset clears control and the entry count; table contents stay undefined
// a result waiting on m_tready does not stop loads or the next lookup's scan
`default_nettype none

module tiered_wildcard_table_match #(
    parameter int MAX_ENTRIES = 64
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // entry_index, entry_driver, mfct_code, version, device_type, zero pad
    input  wire logic [twtm_pkg::S_TDATA_W-1:0]    s_tdata,
    // command
    input  wire logic                              s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // found, driver_number, match_level, zero pad
    output logic      [twtm_pkg::M_TDATA_W-1:0]    m_tdata,
    input  wire logic                              cfg_wr_en,
    input  wire logic [twtm_pkg::COUNT_W-1:0]      cfg_wr_data
);

    localparam int DRV_LSB  = twtm_pkg::IDX_W;
    localparam int MFCT_LSB = DRV_LSB + twtm_pkg::DRV_W;
    localparam int VER_LSB  = MFCT_LSB + twtm_pkg::MFCT_W;
    localparam int TYPE_LSB = VER_LSB + twtm_pkg::VER_W;
    localparam int OUT_W    = 1 + twtm_pkg::DRV_W + twtm_pkg::LEVEL_W;

    twtm_pkg::ctrl_cmd_t          cmd;
    twtm_pkg::dp_status_t         status;
    logic                         found;
    logic [twtm_pkg::DRV_W-1:0]   driver_number;
    logic [twtm_pkg::LEVEL_W-1:0] match_level;

    twtm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .command  (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    twtm_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .entry_index   (s_tdata[twtm_pkg::IDX_W-1:0]),
        .entry_driver  (s_tdata[DRV_LSB +: twtm_pkg::DRV_W]),
        .mfct_code     (s_tdata[MFCT_LSB +: twtm_pkg::MFCT_W]),
        .version       (s_tdata[VER_LSB +: twtm_pkg::VER_W]),
        .device_type   (s_tdata[TYPE_LSB +: twtm_pkg::TYPE_W]),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .found         (found),
        .driver_number (driver_number),
        .match_level   (match_level)
    );

    assign m_tdata = {{(twtm_pkg::M_TDATA_W - OUT_W){1'b0}}, match_level, driver_number, found};

endmodule

`default_nettype wire
